FILE: rtl/core/bspq_pkg.sv
// Shared types and constants for the bounded stable priority queue.
// No dependencies; the cell and the top level take names from here by scope.
package bspq_pkg;

   localparam int CAPACITY       = 16;
   localparam int KEY_BITS       = 16;
   localparam int PAYLOAD_BITS   = 32;
   localparam int COUNT_BITS     = $clog2(CAPACITY + 1);
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 5;
   localparam int LIMIT_BITS     = 5;

   typedef enum logic [1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_CLEAR   = 2'd2,
      CMD_NOP     = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ORDERED_MODE   = 1'b0,
      CSR_CAPACITY_LIMIT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic enq;
      logic deq;
      logic clr;
      logic ordered;
   } cell_ctrl_type;

   typedef struct packed {
      logic                    occ;
      logic [KEY_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0] payload;
   } entry_type;

endpackage

FILE: rtl/core/bspq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbours.
// Depends on bspq_pkg for the entry and control types.
module bspq_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  bspq_pkg::cell_ctrl_type           ctrl,
   input  logic [bspq_pkg::KEY_BITS-1:0]     new_key,
   input  logic [bspq_pkg::PAYLOAD_BITS-1:0] new_payload,
   input  logic                              found_in,
   output logic                              found_out,
   input  bspq_pkg::entry_type               prev_entry,
   input  bspq_pkg::entry_type               next_entry,
   output bspq_pkg::entry_type               entry
);

   logic                              occ_ff, occ_in;
   logic [bspq_pkg::KEY_BITS-1:0]     key_ff, key_in;
   logic [bspq_pkg::PAYLOAD_BITS-1:0] payload_ff, payload_in;
   logic                              gt;
   logic                              take_new;

   assign gt        = ctrl.ordered & occ_ff & (new_key > key_ff);
   assign take_new  = ~found_in & (gt | ~occ_ff);
   assign found_out = found_in | gt | ~occ_ff;

   always_comb begin
      occ_in     = occ_ff;
      key_in     = key_ff;
      payload_in = payload_ff;
      if (ctrl.clr) begin
         occ_in = 1'b0;
      end else if (ctrl.enq) begin
         if (found_in) begin
            occ_in     = prev_entry.occ;
            key_in     = prev_entry.key;
            payload_in = prev_entry.payload;
         end else if (take_new) begin
            occ_in     = 1'b1;
            key_in     = new_key;
            payload_in = new_payload;
         end
      end else if (ctrl.deq) begin
         occ_in     = next_entry.occ;
         key_in     = next_entry.key;
         payload_in = next_entry.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   assign entry = '{occ: occ_ff, key: key_ff, payload: payload_ff};

endmodule

FILE: rtl/core/bounded_stable_priority_queue_top.sv
// Top level of the bounded stable priority queue: chain of bspq_cell slots,
// fill count, configuration registers and the response register. Uses bspq_pkg.
//
//   channel | direction | ports           | beat
//   req     | in        | req_valid/ready | command, rank_key, payload
//   rsp     | out       | rsp_valid/ready | status, out_valid, out_rank_key,
//           |           |                 | out_payload, entry_count
//   csr     | in        | csr_write_*     | one register write, no wait
//
// On each accepted request all slots compare against the new key at once
// and shift in the same edge, with the first-lower search rippling along the chain.
// The response appears in the cycle after its request beat and is held in an
// output register; a new request beat is taken while that register drains.
// Reset empties the queue and sets ordered mode and the full built capacity.
// A stalled response blocks further request beats only while it is not taken.
module bounded_stable_priority_queue_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_command,
   input  logic [bspq_pkg::KEY_BITS-1:0]       req_rank_key,
   input  logic [bspq_pkg::PAYLOAD_BITS-1:0]   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_out_valid,
   output logic [15:0]                         rsp_out_rank_key,
   output logic [31:0]                         rsp_out_payload,
   output logic [4:0]                          rsp_entry_count,
   input  logic                                csr_write_enable,
   input  logic [bspq_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bspq_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int NC = bspq_pkg::CAPACITY;
   localparam int CB = bspq_pkg::COUNT_BITS;

   logic                               ordered_mode_ff;
   logic [bspq_pkg::LIMIT_BITS-1:0]    capacity_limit_ff;
   logic [CB-1:0]                      fill_count_ff, fill_count_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   bspq_pkg::status_type               status_ff, status_in;
   logic                               out_valid_ff, out_valid_in;
   logic [bspq_pkg::KEY_BITS-1:0]      out_key_ff, out_key_in;
   logic [bspq_pkg::PAYLOAD_BITS-1:0]  out_payload_ff, out_payload_in;
   logic [CB-1:0]                      count_out_ff;

   logic                               accept;
   logic [CB-1:0]                      limit;
   logic                               full;
   bspq_pkg::cell_ctrl_type            ctrl;
   bspq_pkg::entry_type                entries [NC];
   logic [NC:0]                        found;
   logic [NC-1:0]                      occ_vec;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   always_comb begin
      if (capacity_limit_ff == '0 || 32'(capacity_limit_ff) > NC) begin
         limit = CB'(NC);
      end else begin
         limit = CB'(capacity_limit_ff);
      end
   end

   assign full = fill_count_ff >= limit;

   always_comb begin
      ctrl           = '0;
      ctrl.ordered   = ordered_mode_ff;
      fill_count_in  = fill_count_ff;
      status_in      = status_ff;
      out_valid_in   = out_valid_ff;
      out_key_in     = out_key_ff;
      out_payload_in = out_payload_ff;
      if (accept) begin
         status_in      = bspq_pkg::STATUS_OK;
         out_valid_in   = 1'b0;
         out_key_in     = '0;
         out_payload_in = '0;
         case (bspq_pkg::command_type'(req_command))
            bspq_pkg::CMD_ENQUEUE: begin
               if (full) begin
                  status_in = bspq_pkg::STATUS_FULL;
               end else begin
                  ctrl.enq      = 1'b1;
                  fill_count_in = fill_count_ff + CB'(1);
               end
            end
            bspq_pkg::CMD_DEQUEUE: begin
               if (fill_count_ff == '0) begin
                  status_in = bspq_pkg::STATUS_EMPTY;
               end else begin
                  ctrl.deq       = 1'b1;
                  out_valid_in   = 1'b1;
                  out_key_in     = entries[0].key;
                  out_payload_in = entries[0].payload;
                  fill_count_in  = fill_count_ff - CB'(1);
               end
            end
            bspq_pkg::CMD_CLEAR: begin
               ctrl.clr      = 1'b1;
               fill_count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   assign found[0] = 1'b0;

   for (genvar i = 0; i < NC; i++) begin : g_cell
      bspq_pkg::entry_type prev_e, next_e;
      if (i == 0) begin : g_first
         assign prev_e = '0;
      end else begin : g_mid
         assign prev_e = entries[i-1];
      end
      if (i == NC - 1) begin : g_last
         assign next_e = '0;
      end else begin : g_inner
         assign next_e = entries[i+1];
      end
      bspq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_key     (req_rank_key),
         .new_payload (req_payload),
         .found_in    (found[i]),
         .found_out   (found[i+1]),
         .prev_entry  (prev_e),
         .next_entry  (next_e),
         .entry       (entries[i])
      );
      assign occ_vec[i] = entries[i].occ;
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         ordered_mode_ff   <= 1'b1;
         capacity_limit_ff <= '0;
         fill_count_ff     <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (bspq_pkg::csr_index_type'(csr_index))
               bspq_pkg::CSR_ORDERED_MODE:   ordered_mode_ff   <= csr_write_data[0];
               bspq_pkg::CSR_CAPACITY_LIMIT: capacity_limit_ff <=
                  bspq_pkg::LIMIT_BITS'(csr_write_data);
               default: begin
               end
            endcase
         end
         fill_count_ff <= fill_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff      <= status_in;
      out_valid_ff   <= out_valid_in;
      out_key_ff     <= out_key_in;
      out_payload_ff <= out_payload_in;
      if (accept) begin
         count_out_ff <= fill_count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_valid    = out_valid_ff;
   assign rsp_out_rank_key = out_key_ff;
   assign rsp_out_payload  = out_payload_ff;
   assign rsp_entry_count  = count_out_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_count_ff) <= NC)
      else $error("fill count above capacity");

   a_occ_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(occ_vec) == 32'(fill_count_ff))
      else $error("slot occupancy disagrees with fill count");

   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_valid_ff |-> status_ff == bspq_pkg::STATUS_OK)
      else $error("returned entry with non-ok status");

   a_full_refused: assert property (@(posedge clock) disable iff (reset)
      accept && req_command == bspq_pkg::CMD_ENQUEUE && full
      |=> status_ff == bspq_pkg::STATUS_FULL && $stable(fill_count_ff))
      else $error("enqueue into full queue not refused");

endmodule
